>>> hdl/htc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htc_pkg: shared types and constants for the heightfield terrain collider
// Word layouts for the request and response channels, the mode codes and
// the control word that drives the heightmap RAM.
// ----------------------------------------------------------------------------
package htc_pkg;

   localparam int CW   = 24;   // field width, 8 fractional bits
   localparam int SW   = 25;   // width of a two-term sum of fields
   localparam int TW   = 23;   // advanced coordinate, never negative
   localparam int IDXW = 6;    // grid_col / grid_row width

   localparam logic signed [CW-1:0] H_MAX = 24'sh7FFFFF;
   localparam logic signed [CW-1:0] H_MIN = 24'sh800000;

   typedef enum logic {
      MODE_COLLIDE = 1'b0,
      MODE_LOAD    = 1'b1
   } htc_mode_type;

   typedef struct packed {
      htc_mode_type         mode;
      logic signed [CW-1:0] pos_x;
      logic signed [CW-1:0] pos_y;
      logic signed [CW-1:0] pos_z;
      logic signed [CW-1:0] vel_x;
      logic signed [CW-1:0] vel_y;
      logic signed [CW-1:0] vel_z;
      logic [IDXW-1:0]      grid_col;
      logic [IDXW-1:0]      grid_row;
      logic signed [CW-1:0] height_value;
   } htc_req_type;

   typedef struct packed {
      logic signed [CW-1:0] new_pos_x;
      logic signed [CW-1:0] new_pos_y;
      logic signed [CW-1:0] new_pos_z;
      logic signed [CW-1:0] new_vel_x;
      logic signed [CW-1:0] new_vel_y;
      logic signed [CW-1:0] new_vel_z;
      logic signed [CW-1:0] ground_height;
      logic                 hit_ground;
   } htc_rsp_type;

   typedef struct packed {
      logic wr_en;   // store one height
      logic rd_en;   // capture the three corner heights
   } htc_ram_ctl_type;

endpackage

>>> hdl/htc_height_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htc_height_ram: heightmap storage, three replicas
// Every write goes to all three copies; each copy has one registered read
// port, so three corners of a cell come back in the same cycle.
// ----------------------------------------------------------------------------
module htc_height_ram
   import htc_pkg::*;
#(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
)(
   input  logic                 clock,
   input  htc_ram_ctl_type      ctl,
   input  logic [AW-1:0]        wr_addr,
   input  logic signed [CW-1:0] wr_data,
   input  logic [AW-1:0]        rd_addr_a,
   input  logic [AW-1:0]        rd_addr_b,
   input  logic [AW-1:0]        rd_addr_c,
   output logic signed [CW-1:0] rd_data_a,
   output logic signed [CW-1:0] rd_data_b,
   output logic signed [CW-1:0] rd_data_c
);

   logic signed [CW-1:0] mem_a [DEPTH];
   logic signed [CW-1:0] mem_b [DEPTH];
   logic signed [CW-1:0] mem_c [DEPTH];

   logic signed [CW-1:0] rd_a_ff;
   logic signed [CW-1:0] rd_b_ff;
   logic signed [CW-1:0] rd_c_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_a[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_a_ff <= mem_a[rd_addr_a];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_b[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_b_ff <= mem_b[rd_addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_c[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_c_ff <= mem_c[rd_addr_c];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;
   assign rd_data_c = rd_c_ff;

endmodule

>>> hdl/heightfield_terrain_collide.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heightfield_terrain_collide: object versus heightmap terrain collision
// Clamps an object to the map border and lifts it onto the triangulated
// ground surface; load words fill the heightmap.
// ----------------------------------------------------------------------------
// The block accepts one word per cycle while the response side keeps up; a
// stall on rsp holds it. A collide word's result shows on rsp once it has
// passed S1 to S6 and the response register. A load word (mode 1)
// writes one height at (grid_col, grid_row)
// and returns nothing; loads outside the grid are dropped. A collide word
// (mode 0) is clamped on x and z to [0, far border], far border being
// (GRID-1) cells capped at the largest position. The ground height at the
// advanced point is interpolated over the lower or upper triangle of its
// cell (rounded to nearest, halves up, saturated), and pos_y / vel_y are
// replaced when the advanced y is below ground. Heights are held in three
// copies of a GRID*GRID RAM, so the three corners of a cell are read in the
// same cycle; this and the two 25x14 multipliers set the one-per-cycle rate.
// Heights that were never loaded read back as whatever the RAM holds.
// Pipeline: S1 input reg / border clamp, S2 cell split and RAM access,
// S3 corner deltas, S4 multiply, S5 sum and round, S6 ground and hit,
// then the response register. A stall holds only full stages with no gap below.
// ----------------------------------------------------------------------------
module heightfield_terrain_collide
   import htc_pkg::*;
#(
   parameter int GRID       = 64,
   parameter int CELL_SHIFT = 12
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  htc_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output htc_rsp_type rsp_data
);

   localparam int DEPTH = GRID * GRID;
   localparam int AW    = $clog2(DEPTH);
   localparam int IXW   = $clog2(GRID);
   localparam int FW    = CELL_SHIFT + 1;        // fraction up to one full cell
   localparam int IRW   = TW - CELL_SHIFT;       // raw cell index width
   localparam int PW    = SW + FW + 1;           // delta times weight
   localparam int SUMW  = PW + 1;
   localparam int QW    = SUMW - CELL_SHIFT;
   localparam int HW    = QW + 1;

   localparam longint FAR_RAW = longint'(GRID - 1) << CELL_SHIFT;
   localparam longint FAR_SAT = (FAR_RAW > longint'(H_MAX)) ? longint'(H_MAX) : FAR_RAW;
   localparam logic [TW-1:0] FAR  = TW'(FAR_SAT);
   localparam logic [FW-1:0] CELL = FW'(1) << CELL_SHIFT;
   localparam logic signed [SUMW-1:0] HALF = SUMW'(1) << (CELL_SHIFT - 1);

   // object state carried along the pipe
   typedef struct packed {
      logic signed [CW-1:0] pos_x;
      logic signed [CW-1:0] pos_y;
      logic signed [CW-1:0] pos_z;
      logic signed [CW-1:0] vel_x;
      logic signed [CW-1:0] vel_y;
      logic signed [CW-1:0] vel_z;
      logic signed [SW-1:0] ysum;     // advanced y
   } kin_type;

   typedef struct packed {
      logic signed [CW-1:0] pos;
      logic signed [CW-1:0] vel;
      logic [TW-1:0]        adv;
   } axis_type;

   function automatic axis_type clamp_axis(input logic signed [CW-1:0] p,
                                           input logic signed [CW-1:0] v);
      logic signed [SW-1:0] s;
      axis_type             r;
      s = SW'(p) + SW'(v);
      if (s < 0) begin
         r.pos = '0;
         r.vel = '0;
         r.adv = '0;
      end else if (s > $signed({2'b00, FAR})) begin
         r.pos = $signed({1'b0, FAR});
         r.vel = '0;
         r.adv = FAR;
      end else begin
         r.pos = p;
         r.vel = v;
         r.adv = s[TW-1:0];
      end
      return r;
   endfunction

   // ---------------------------------------------------------------- flow
   logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s5_valid_ff, s6_valid_ff, rsp_valid_ff;

   // a stage takes a new word when it is empty or its word moves on
   assign rdy7 = !rsp_valid_ff || !rsp_stall;
   assign rdy6 = !s6_valid_ff || rdy7;
   assign rdy5 = !s5_valid_ff || rdy6;
   assign rdy4 = !s4_valid_ff || rdy5;
   assign rdy3 = !s3_valid_ff || rdy4;
   assign rdy2 = !s2_valid_ff || rdy3;
   assign rdy1 = !s1_valid_ff || rdy2;

   assign req_stall = !rdy1;

   // ---------------------------------------------------------------- S1
   htc_req_type s1_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (rdy1) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_data_ff <= req_data;
      end
   end

   axis_type s1_ax, s1_az;
   kin_type  s2_kin_in;

   always_comb begin
      s1_ax = clamp_axis(s1_data_ff.pos_x, s1_data_ff.vel_x);
      s1_az = clamp_axis(s1_data_ff.pos_z, s1_data_ff.vel_z);
      s2_kin_in.pos_x = s1_ax.pos;
      s2_kin_in.vel_x = s1_ax.vel;
      s2_kin_in.pos_z = s1_az.pos;
      s2_kin_in.vel_z = s1_az.vel;
      s2_kin_in.pos_y = s1_data_ff.pos_y;
      s2_kin_in.vel_y = s1_data_ff.vel_y;
      s2_kin_in.ysum  = SW'(s1_data_ff.pos_y) + SW'(s1_data_ff.vel_y);
   end

   // ---------------------------------------------------------------- S2
   htc_mode_type         s2_mode_ff;
   kin_type              s2_kin_ff;
   logic [TW-1:0]        s2_tx_ff, s2_tz_ff;
   logic [IDXW-1:0]      s2_col_ff, s2_row_ff;
   logic signed [CW-1:0] s2_hval_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (rdy2) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         s2_mode_ff <= s1_data_ff.mode;
         s2_kin_ff  <= s2_kin_in;
         s2_tx_ff   <= s1_ax.adv;
         s2_tz_ff   <= s1_az.adv;
         s2_col_ff  <= s1_data_ff.grid_col;
         s2_row_ff  <= s1_data_ff.grid_row;
         s2_hval_ff <= s1_data_ff.height_value;
      end
   end

   logic [IRW-1:0] ixr, izr;
   logic [IXW-1:0] ix, iz;
   logic [TW-1:0]  fx_full, fz_full;
   logic [FW-1:0]  s3_fx_in, s3_fz_in;
   logic           s3_lower_in;
   logic [AW-1:0]  cell_base, addr_a, addr_b, addr_c, wr_addr;
   logic           wr_in_grid;

   always_comb begin
      ixr = s2_tx_ff[TW-1:CELL_SHIFT];
      izr = s2_tz_ff[TW-1:CELL_SHIFT];
      // far edge: a point on the border stays in the last cell, fraction one cell
      ix  = (int'(ixr) > GRID - 2) ? IXW'(GRID - 2) : IXW'(ixr);
      iz  = (int'(izr) > GRID - 2) ? IXW'(GRID - 2) : IXW'(izr);
      fx_full  = s2_tx_ff - (TW'(ix) << CELL_SHIFT);
      fz_full  = s2_tz_ff - (TW'(iz) << CELL_SHIFT);
      s3_fx_in = fx_full[FW-1:0];
      s3_fz_in = fz_full[FW-1:0];
      s3_lower_in = ((FW+1)'(s3_fx_in) + (FW+1)'(s3_fz_in)) < (FW+1)'(CELL);

      cell_base = AW'(ix) * AW'(GRID) + AW'(iz);
      // port a: h00 on the lower triangle, h11 on the upper
      addr_a = s3_lower_in ? cell_base : cell_base + AW'(GRID + 1);
      addr_b = cell_base + AW'(1);           // h01
      addr_c = cell_base + AW'(GRID);        // h10

      wr_in_grid = (int'(s2_col_ff) < GRID) && (int'(s2_row_ff) < GRID);
      wr_addr    = AW'(s2_col_ff) * AW'(GRID) + AW'(s2_row_ff);
   end

   // RAM access happens as a word leaves S2, so reads and writes keep word order
   htc_ram_ctl_type      ram_ctl;
   logic signed [CW-1:0] h_a, h_b, h_c;

   assign ram_ctl.wr_en = rdy3 && s2_valid_ff && (s2_mode_ff == MODE_LOAD) && wr_in_grid;
   assign ram_ctl.rd_en = rdy3;

   htc_height_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock     (clock),
      .ctl       (ram_ctl),
      .wr_addr   (wr_addr),
      .wr_data   (s2_hval_ff),
      .rd_addr_a (addr_a),
      .rd_addr_b (addr_b),
      .rd_addr_c (addr_c),
      .rd_data_a (h_a),
      .rd_data_b (h_b),
      .rd_data_c (h_c)
   );

   // ---------------------------------------------------------------- S3
   kin_type       s3_kin_ff;
   logic [FW-1:0] s3_fx_ff, s3_fz_ff;
   logic          s3_lower_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (rdy3) begin
         // loads end here
         s3_valid_ff <= s2_valid_ff && (s2_mode_ff == MODE_COLLIDE);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         s3_kin_ff   <= s2_kin_ff;
         s3_fx_ff    <= s3_fx_in;
         s3_fz_ff    <= s3_fz_in;
         s3_lower_ff <= s3_lower_in;
      end
   end

   logic signed [SW-1:0] s4_db_in, s4_dc_in;
   logic [FW-1:0]        s4_wb_in, s4_wc_in;

   always_comb begin
      s4_db_in = SW'(h_b) - SW'(h_a);
      s4_dc_in = SW'(h_c) - SW'(h_a);
      s4_wb_in = s3_lower_ff ? s3_fz_ff : CELL - s3_fx_ff;
      s4_wc_in = s3_lower_ff ? s3_fx_ff : CELL - s3_fz_ff;
   end

   // ---------------------------------------------------------------- S4
   kin_type              s4_kin_ff;
   logic signed [CW-1:0] s4_base_ff;
   logic signed [SW-1:0] s4_db_ff, s4_dc_ff;
   logic [FW-1:0]        s4_wb_ff, s4_wc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (rdy4) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         s4_kin_ff  <= s3_kin_ff;
         s4_base_ff <= h_a;
         s4_db_ff   <= s4_db_in;
         s4_dc_ff   <= s4_dc_in;
         s4_wb_ff   <= s4_wb_in;
         s4_wc_ff   <= s4_wc_in;
      end
   end

   logic signed [PW-1:0] s5_pb_in, s5_pc_in;

   assign s5_pb_in = s4_db_ff * $signed({1'b0, s4_wb_ff});
   assign s5_pc_in = s4_dc_ff * $signed({1'b0, s4_wc_ff});

   // ---------------------------------------------------------------- S5
   kin_type              s5_kin_ff;
   logic signed [CW-1:0] s5_base_ff;
   logic signed [PW-1:0] s5_pb_ff, s5_pc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (rdy5) begin
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy5) begin
         s5_kin_ff  <= s4_kin_ff;
         s5_base_ff <= s4_base_ff;
         s5_pb_ff   <= s5_pb_in;
         s5_pc_ff   <= s5_pc_in;
      end
   end

   logic signed [SUMW-1:0] interp_sum, interp_shr;
   logic signed [QW-1:0]   s6_q_in;

   // divide by one cell, round to nearest with halves up
   always_comb begin
      interp_sum = SUMW'(s5_pb_ff) + SUMW'(s5_pc_ff) + HALF;
      interp_shr = interp_sum >>> CELL_SHIFT;
      s6_q_in    = interp_shr[QW-1:0];
   end

   // ---------------------------------------------------------------- S6
   kin_type              s6_kin_ff;
   logic signed [CW-1:0] s6_base_ff;
   logic signed [QW-1:0] s6_q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (rdy6) begin
         s6_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy6) begin
         s6_kin_ff  <= s5_kin_ff;
         s6_base_ff <= s5_base_ff;
         s6_q_ff    <= s6_q_in;
      end
   end

   logic signed [HW-1:0] ground_full;
   logic signed [CW-1:0] ground;
   logic                 hit;
   htc_rsp_type          rsp_data_in;

   always_comb begin
      ground_full = HW'(s6_base_ff) + HW'(s6_q_ff);
      if (ground_full > HW'(H_MAX)) begin
         ground = H_MAX;
      end else if (ground_full < HW'(H_MIN)) begin
         ground = H_MIN;
      end else begin
         ground = ground_full[CW-1:0];
      end
      hit = s6_kin_ff.ysum < SW'(ground);

      rsp_data_in.new_pos_x     = s6_kin_ff.pos_x;
      rsp_data_in.new_pos_z     = s6_kin_ff.pos_z;
      rsp_data_in.new_vel_x     = s6_kin_ff.vel_x;
      rsp_data_in.new_vel_z     = s6_kin_ff.vel_z;
      rsp_data_in.new_pos_y     = hit ? ground : s6_kin_ff.pos_y;
      rsp_data_in.new_vel_y     = hit ? '0 : s6_kin_ff.vel_y;
      rsp_data_in.ground_height = ground;
      rsp_data_in.hit_ground    = hit;
   end

   // ---------------------------------------------------------------- output
   htc_rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rdy7) begin
         rsp_valid_ff <= s6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy7) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> hdl/htc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htc_checker: port-level checks for the terrain collider
// Watches the response channel for word hold and for the collision
// invariants that every result must meet.
// ----------------------------------------------------------------------------
module htc_checker
   import htc_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input htc_rsp_type rsp_data
);

   logic signed [SW-1:0] adv_x, adv_y, adv_z, gnd;

   assign adv_x = SW'(rsp_data.new_pos_x) + SW'(rsp_data.new_vel_x);
   assign adv_y = SW'(rsp_data.new_pos_y) + SW'(rsp_data.new_vel_y);
   assign adv_z = SW'(rsp_data.new_pos_z) + SW'(rsp_data.new_vel_z);
   assign gnd   = SW'(rsp_data.ground_height);

   // nothing comes out right after reset
   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response word right after reset");

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response word changed");

   // advanced point is never below zero on x and z
   a_inside_border: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (adv_x >= 0) && (adv_z >= 0))
      else $error("advanced point left the map");

   // a hit sits on the ground at rest
   a_hit_rest: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.hit_ground |->
         (rsp_data.new_pos_y == rsp_data.ground_height) && (rsp_data.new_vel_y == '0))
      else $error("hit word not placed on ground");

   // no hit means the advanced y is on or above the ground
   a_miss_above: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit_ground |-> adv_y >= gnd)
      else $error("miss word below ground");

endmodule

bind heightfield_terrain_collide htc_checker u_htc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

>>> sim/tb_heightfield_terrain_collide.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_heightfield_terrain_collide: self-checking bench for the terrain collider
// Loads the corners of every cell before a collide reads it, runs a directed
// set of border, far-edge and triangle cases, then random load and collide
// words under three idle patterns. A scoreboard predicts every collide
// result and checks it in order.
// ----------------------------------------------------------------------------
module tb_heightfield_terrain_collide;
   import htc_pkg::*;

   localparam int     GRID       = 64;
   localparam int     CELL_SHIFT = 12;
   localparam longint CELL       = longint'(1) << CELL_SHIFT;
   localparam longint HI         = 8388607;
   localparam longint LO         = -8388608;
   // far border, capped at the largest position
   localparam longint FAR_RAW    = longint'(GRID - 1) << CELL_SHIFT;
   localparam longint FAR        = (FAR_RAW > HI) ? HI : FAR_RAW;
   localparam int     LIMIT      = 400000;   // cycles before the watchdog fires
   localparam int     DRAIN      = 32;       // pipeline is 7 deep, plenty of slack

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   htc_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   htc_rsp_type rsp_data;

   // percent chance per cycle of a sender gap / a receiver stall
   int send_idle_pct;
   int recv_stall_pct;

   // cell of the latest load and of the latest collide, used to aim the
   // random words at each other so read-after-write paths get exercised
   int last_col;
   int last_row;
   int near_col;
   int near_row;

   // heightmap entries already written, and words taken so far
   bit loaded [GRID][GRID];
   int sent_words;

   int cycle_count;

   heightfield_terrain_collide #(
      .GRID       (GRID),
      .CELL_SHIFT (CELL_SHIFT)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // -------------------------------------------------------------------------
   // Scoreboard: keeps its own copy of the heightmap, predicts each collide
   // word's result when the word is accepted, and checks results in order.
   // -------------------------------------------------------------------------
   class terrain_scoreboard;
      longint      height_map [GRID][GRID];
      htc_rsp_type expected_rsp [$];
      int          mismatches;

      // divide by one cell, round to nearest, halves up
      function longint round_cell(longint sum);
         return (sum + (CELL >>> 1)) >>> CELL_SHIFT;
      endfunction

      // cell index and fraction; a point on the far border stays in the
      // last cell with a full-cell fraction
      function void split_axis(longint t, output longint idx, output longint frac);
         idx = t >>> CELL_SHIFT;
         if (idx > GRID - 2)
            idx = GRID - 2;
         frac = t - (idx << CELL_SHIFT);
      endfunction

      function longint ground_at(longint tx, longint tz);
         longint ix, iz, fx, fz;
         longint h00, h01, h10, h11, h;
         split_axis(tx, ix, fx);
         split_axis(tz, iz, fz);
         h01 = height_map[ix][iz + 1];
         h10 = height_map[ix + 1][iz];
         if (fx + fz < CELL) begin
            h00 = height_map[ix][iz];
            h = h00 + round_cell(fz * (h01 - h00) + fx * (h10 - h00));
         end else begin
            h11 = height_map[ix + 1][iz + 1];
            h = h11 + round_cell((CELL - fz) * (h10 - h11) + (CELL - fx) * (h01 - h11));
         end
         if (h > HI)
            h = HI;
         if (h < LO)
            h = LO;
         return h;
      endfunction

      function void clamp_axis(inout longint p, inout longint v);
         longint s;
         s = p + v;
         if (s < 0) begin
            p = 0;
            v = 0;
         end else if (s > FAR) begin
            p = FAR;
            v = 0;
         end
      endfunction

      function void note_word(htc_req_type w);
         longint      px, py, pz, vx, vy, vz, h;
         htc_rsp_type r;
         if (w.mode == MODE_LOAD) begin
            if (w.grid_col < GRID && w.grid_row < GRID)
               height_map[w.grid_col][w.grid_row] = $signed(w.height_value);
            return;
         end
         px = $signed(w.pos_x);
         py = $signed(w.pos_y);
         pz = $signed(w.pos_z);
         vx = $signed(w.vel_x);
         vy = $signed(w.vel_y);
         vz = $signed(w.vel_z);
         clamp_axis(px, vx);
         clamp_axis(pz, vz);
         h = ground_at(px + vx, pz + vz);
         r.hit_ground = (py + vy) < h;
         if (r.hit_ground) begin
            py = h;
            vy = 0;
         end
         r.new_pos_x     = CW'(px);
         r.new_pos_y     = CW'(py);
         r.new_pos_z     = CW'(pz);
         r.new_vel_x     = CW'(vx);
         r.new_vel_y     = CW'(vy);
         r.new_vel_z     = CW'(vz);
         r.ground_height = CW'(h);
         expected_rsp.insert(expected_rsp.size(), r);
      endfunction

      function void compare_field(string name, logic signed [CW-1:0] want,
                                  logic signed [CW-1:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(htc_rsp_type got);
         htc_rsp_type want;
         if (expected_rsp.size() == 0) begin
            $display("%0t: result word expected none, got %h", $time, got);
            mismatches++;
            return;
         end
         want = expected_rsp.pop_front();
         compare_field("new_pos_x", want.new_pos_x, got.new_pos_x);
         compare_field("new_pos_y", want.new_pos_y, got.new_pos_y);
         compare_field("new_pos_z", want.new_pos_z, got.new_pos_z);
         compare_field("new_vel_x", want.new_vel_x, got.new_vel_x);
         compare_field("new_vel_y", want.new_vel_y, got.new_vel_y);
         compare_field("new_vel_z", want.new_vel_z, got.new_vel_z);
         compare_field("ground_height", want.ground_height, got.ground_height);
         compare_field("hit_ground", want.hit_ground, got.hit_ground);
      endfunction
   endclass

   terrain_scoreboard board = new();

   // -------------------------------------------------------------------------
   // Clock, watchdog
   // -------------------------------------------------------------------------
   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_heightfield_terrain_collide failed");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Response side: stall is redrawn each edge; a word is taken at the edge
   // where valid is high and stall low, so both are sampled at the falling
   // edge before it, when they are settled.
   // -------------------------------------------------------------------------
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   initial begin
      forever begin
         @(negedge clock);
         if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0)
            board.check_result(rsp_data);
      end
   end

   // -------------------------------------------------------------------------
   // Value helpers
   // -------------------------------------------------------------------------
   function automatic longint spread(longint span);
      return longint'($urandom_range(0, 32'(2 * span))) - span;
   endfunction

   function automatic longint any24();
      logic signed [CW-1:0] t;
      t = CW'($urandom);
      return t;
   endfunction

   function automatic longint fit_axis(longint t);
      if (t < 0)
         return 0;
      if (t > FAR)
         return FAR;
      return t;
   endfunction

   function automatic longint random_height();
      if ($urandom_range(7) == 0)
         return any24();
      return spread(16384);   // +-64 units, close to typical object heights
   endfunction

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------
   // Holds the word until it is taken; the scoreboard sees it at that edge.
   task automatic send_word(input htc_req_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do
         @(negedge clock);
      while (req_stall !== 1'b0);
      @(posedge clock);
      board.note_word(w);
      sent_words++;
   endtask

   // unused fields of each word carry random bits
   task automatic send_load(input int col, input int row, input longint h);
      htc_req_type w;
      w              = $bits(htc_req_type)'({$urandom, $urandom, $urandom,
                                             $urandom, $urandom, $urandom});
      w.mode         = MODE_LOAD;
      w.grid_col     = IDXW'(col);
      w.grid_row     = IDXW'(row);
      w.height_value = CW'(h);
      last_col       = col;
      last_row       = row;
      loaded[col][row] = 1'b1;
      send_word(w);
   endtask

   // writes any corner of the cell that was never loaded
   task automatic fill_cell(input int ix, input int iz);
      for (int dx = 0; dx < 2; dx++)
         for (int dz = 0; dz < 2; dz++)
            if (!loaded[ix + dx][iz + dz])
               send_load(ix + dx, iz + dz, random_height());
   endtask

   task automatic send_collide(input longint px, input longint py, input longint pz,
                               input longint vx, input longint vy, input longint vz);
      htc_req_type w;
      longint      cx, cz;
      w        = $bits(htc_req_type)'({$urandom, $urandom, $urandom,
                                       $urandom, $urandom, $urandom});
      w.mode   = MODE_COLLIDE;
      w.pos_x  = CW'(px);
      w.pos_y  = CW'(py);
      w.pos_z  = CW'(pz);
      w.vel_x  = CW'(vx);
      w.vel_y  = CW'(vy);
      w.vel_z  = CW'(vz);
      cx       = fit_axis(px + vx) >>> CELL_SHIFT;
      cz       = fit_axis(pz + vz) >>> CELL_SHIFT;
      near_col = (cx > GRID - 2) ? GRID - 2 : int'(cx);
      near_row = (cz > GRID - 2) ? GRID - 2 : int'(cz);
      fill_cell(near_col, near_row);
      send_word(w);
   endtask

   // Loads land on the corners of the latest collide cell half the time.
   task automatic random_load();
      int col, row;
      if ($urandom_range(1) == 0) begin
         col = near_col + $urandom_range(1);
         row = near_row + $urandom_range(1);
      end else begin
         col = $urandom_range(GRID - 1);
         row = $urandom_range(GRID - 1);
      end
      send_load(col, row, random_height());
   endtask

   // Collides: aimed at the latest load, spread over the map, or raw noise
   // that mostly ends up clamped at a border.
   task automatic random_collide();
      longint px, py, pz, vx, vy, vz;
      int     pick;
      pick = $urandom_range(99);
      if (pick < 40) begin
         px = fit_axis((longint'(last_col) << CELL_SHIFT) + spread(CELL));
         pz = fit_axis((longint'(last_row) << CELL_SHIFT) + spread(CELL));
         vx = spread(256);
         vz = spread(256);
      end else if (pick < 80) begin
         px = longint'($urandom_range(0, 32'(FAR)));
         pz = longint'($urandom_range(0, 32'(FAR)));
         if ($urandom_range(7) == 0)
            px = FAR;
         if ($urandom_range(7) == 0)
            pz = ($urandom_range(1) == 0) ? 0 : FAR;
         vx = spread(2048);
         vz = spread(2048);
      end else begin
         px = any24();
         pz = any24();
         vx = any24();
         vz = any24();
      end
      py = spread(16384);
      vy = spread(1024);
      if ($urandom_range(7) == 0) begin
         py = any24();
         vy = any24();
      end
      send_collide(px, py, pz, vx, vy, vz);
   endtask

   // corner loads that a collide needs count toward the word budget
   task automatic random_words(input int count);
      int target;
      target = sent_words + count;
      while (sent_words < target) begin
         if ($urandom_range(99) < 30)
            random_load();
         else
            random_collide();
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      send_idle_pct  = 30;
      recv_stall_pct = 66;
      last_col       = 0;
      last_row       = 0;
      near_col       = 0;
      near_row       = 0;
      sent_words     = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Every collide first loads the corners of its cell that were never
      // written, so no read ever hits an entry that was never loaded.

      // Directed: height extremes in cell (0,0) and the far corner cell.
      send_load(0, 0, HI);
      send_load(1, 0, LO);
      send_load(0, 1, -1);
      send_load(1, 1, HI);
      send_load(GRID - 1, GRID - 1, LO);
      send_load(GRID - 2, GRID - 1, HI);
      // y sum at the bottom of the range under the highest ground: hit
      send_collide(0, LO, 0, 0, LO, 0);
      // y exactly on the ground: no hit
      send_collide(0, HI, 0, 0, 0, 0);
      // x clamped high, z clamped low, y sum at the top of the range
      send_collide(HI, HI, LO, HI, HI, LO);
      // both sums land at -1: clamp to zero
      send_collide(LO, 0, HI, HI, 0, LO);
      // far edge on both axes, position alone and through the sum
      send_collide(FAR, 0, FAR, 0, 0, 0);
      send_collide(FAR - 1, 0, FAR - 5, 1, 0, 5);
      // one past the far border, and one below zero
      send_collide(FAR, 0, 0, 1, 0, 0);
      send_collide(0, 0, 0, -1, 0, -1);
      // triangle choice: inside lower, just under the diagonal, on it, upper
      send_collide(100, 0, 200, 0, 0, 0);
      send_collide(2047, 0, 2048, 0, 0, 0);
      send_collide(2048, 0, 2048, 0, 0, 0);
      send_collide(4095, 0, 4095, 0, 0, 0);
      // load then an immediate read of the same corner
      send_load(0, 0, 12345);
      send_collide(0, 0, 0, 0, LO, 0);

      random_words(140);
      send_idle_pct  = 66;
      recv_stall_pct = 30;
      random_words(140);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      random_words(140);
      req_valid <= 1'b0;

      while (board.expected_rsp.size() != 0)
         @(posedge clock);
      repeat (DRAIN) @(posedge clock);

      if (board.mismatches == 0 && board.expected_rsp.size() == 0)
         $display("tb_heightfield_terrain_collide passed");
      else
         $display("tb_heightfield_terrain_collide failed");
      $finish;
   end

endmodule

>>> files.f
hdl/htc_pkg.sv
hdl/htc_height_ram.sv
hdl/heightfield_terrain_collide.sv
hdl/htc_checker.sv
sim/tb_heightfield_terrain_collide.sv
